### rtl/gif_lzw_encoder_macros.svh
// Assertion helpers for the GIF LZW encoder
`ifndef GIF_LZW_ENCODER_MACROS_SVH
`define GIF_LZW_ENCODER_MACROS_SVH

// Clocked implication, held off while reset is low
`define GLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Clocked next-cycle implication, held off while reset is low
`define GLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gle_pkg.sv
// ----------------------------------------------------------------------------
// gle_pkg
// Shared types and constants of the GIF LZW encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gle_pkg;

  localparam int TableDepthDef  = 4096;
  localparam int MaxCodeBitsDef = 12;

  localparam int CodeW  = 12;
  localparam int WidthW = 4;
  localparam int McsW   = 4;
  localparam int PixW   = 8;

  localparam logic [McsW-1:0] McsMin   = 4'd2;
  localparam logic [McsW-1:0] McsMax   = 4'd8;
  localparam logic [McsW-1:0] McsReset = 4'd8;

  // register index of min_code_size
  localparam int RegMcs = 0;

  // result queue
  localparam int OqDepth = 8;
  localparam int OqPtrW  = $clog2(OqDepth);

  typedef struct packed {
    logic [PixW-1:0] pixel_index;
    logic            frame_start;
    logic            frame_end;
  } in_beat_t;

  typedef struct packed {
    logic [CodeW-1:0]  code_value;
    logic [WidthW-1:0] code_width;
    logic              last_of_run;
    logic              symbol_error;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic clr_step;
    logic dict_rd;
    logic probe_next;
    logic hit;
    logic miss;
    logic full_clear;
    logic flush;
    logic eoi;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic drop;
    logic item_fs;
    logic item_fe;
    logic fe_q;
    logic clr_done;
    logic slot_valid;
    logic key_match;
    logic table_full;
    logic oq_room;
  } status_t;

endpackage

`default_nettype wire

### rtl/gif_lzw_encoder.sv
// A frame-start pixel is handled on accept, with flush and end-of-information codes after it
// on frame end; a later pixel is accepted, then each hash slot probed takes a slot read, then a
// code-table read, followed by a table clear on a full table and a flush and end on frame end.
// Results leave through an 8-deep queue, 1 beat per cycle while out_ready_i is high.
// Reset clears all control state and starts a clearing sweep of all 2*TABLE_DEPTH hash
// slots (8192 by default), during which no pixel is taken.
// ----------------------------------------------------------------------------
// gif_lzw_encoder
// Variable-width LZW code generator for GIF pixel data with an APB register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gif_lzw_encoder_macros.svh"

module gif_lzw_encoder #(
  parameter int TABLE_DEPTH   = gle_pkg::TableDepthDef,
  parameter int MAX_CODE_BITS = gle_pkg::MaxCodeBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire gle_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gle_pkg::out_beat_t      out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import gle_pkg::*;

  logic [McsW-1:0] mcs_q;
  logic            reg_sel;
  cmd_t            cmd;
  status_t         st;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = paddr[2:2] == 1'(RegMcs);
  assign prdata  = reg_sel ? {{(32-McsW){1'b0}}, mcs_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcs_q <= McsReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      mcs_q <= pwdata[McsW-1:0];
    end
  end

  gle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  gle_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mcs_i       (mcs_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // checks
  `GLE_ASSERT_IMP(a_width_range, out_valid_o, (out_data_o.code_width >= 4'd3) && (out_data_o.code_width <= 4'd12), "code width out of range")
  `GLE_ASSERT_IMP(a_no_take_in_sweep, cmd.clr_step, !in_ready_o, "pixel taken during clearing sweep")
  `GLE_ASSERT_NEXT(a_start_gives_clear, in_valid_i && in_ready_o && in_data_i.frame_start, out_valid_o, "frame start gave no clear code")

endmodule

`default_nettype wire

### rtl/gle_ctrl.sv
// ----------------------------------------------------------------------------
// gle_ctrl
// Sequencer of the encoder: clearing sweep, accept, hash probe, emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gle_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire gle_pkg::status_t st_i,
  output gle_pkg::cmd_t        cmd_o
);
  import gle_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE_A,
    S_PROBE_B,
    S_FULL,
    S_FLUSH,
    S_EOI
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == S_IDLE) && st_i.oq_room;
  assign take       = in_ready_o && in_valid_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          cmd_o.accept = 1'b1;
          if (st_i.drop) begin
            state_d = S_IDLE;
          end else if (st_i.item_fs) begin
            state_d = st_i.item_fe ? S_FLUSH : S_IDLE;
          end else begin
            state_d = S_PROBE_A;
          end
        end
      end
      S_PROBE_A: begin
        cmd_o.dict_rd = 1'b1;
        state_d       = S_PROBE_B;
      end
      S_PROBE_B: begin
        if (!st_i.slot_valid) begin
          cmd_o.miss = 1'b1;
          if (st_i.table_full) state_d = S_FULL;
          else                 state_d = st_i.fe_q ? S_FLUSH : S_IDLE;
        end else if (st_i.key_match) begin
          cmd_o.hit = 1'b1;
          state_d   = st_i.fe_q ? S_FLUSH : S_IDLE;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = S_PROBE_A;
        end
      end
      S_FULL: begin
        cmd_o.full_clear = 1'b1;
        state_d          = st_i.fe_q ? S_FLUSH : S_IDLE;
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = S_EOI;
      end
      S_EOI: begin
        cmd_o.eoi = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/gle_dp.sv
// ----------------------------------------------------------------------------
// gle_dp
// Encoder datapath: code state, hash slot table, code table, result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gle_dp #(
  parameter int TABLE_DEPTH   = gle_pkg::TableDepthDef,
  parameter int MAX_CODE_BITS = gle_pkg::MaxCodeBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [gle_pkg::McsW-1:0]     mcs_i,
  input  wire gle_pkg::in_beat_t            in_data_i,
  input  wire gle_pkg::cmd_t                cmd_i,
  output gle_pkg::status_t                  st_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output gle_pkg::out_beat_t                out_data_o
);
  import gle_pkg::*;

  localparam int DW = $clog2(TABLE_DEPTH);
  localparam int HB = DW + 1;
  localparam int HD = 2 ** HB;
  localparam int CodeLimit = (TABLE_DEPTH < 2 ** MAX_CODE_BITS) ?
                             TABLE_DEPTH : 2 ** MAX_CODE_BITS;
  localparam int KeyW = CodeW + PixW;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [KeyW-1:0]  key;
  } slot_t;

  function automatic logic [McsW-1:0] clamp_mcs(input logic [McsW-1:0] m);
    logic [McsW-1:0] r;
    r = m;
    if (m < McsMin) r = McsMin;
    if (m > McsMax) r = McsMax;
    return r;
  endfunction

  // code state
  logic [CodeW:0]    nf_q, nf_d;
  logic [WidthW-1:0] width_q, width_d;
  logic [McsW-1:0]   fmcs_q, fmcs_d;
  logic [CodeW-1:0]  cur_q, cur_d;
  logic [PixW-1:0]   k_q, k_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [HB-1:0]     s_q, s_d;
  logic              fe_q, fe_d;
  logic              active_q, active_d;
  logic              err_q, err_d;
  logic              serr_q, serr_d;
  logic [HB-1:0]     clr_cnt_q;

  // memories
  slot_t             slot_mem [HD];
  slot_t             slot_rd_q;
  logic [HB-1:0]     dict_mem [TABLE_DEPTH];
  logic [HB-1:0]     dict_rd_q;

  // result queue
  out_beat_t         oq_mem [OqDepth];
  logic [OqPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OqPtrW:0]   cnt_q;
  logic              push, pop;
  out_beat_t         push_data;

  // item decode at accept
  logic [McsW-1:0]   mcs_new;
  logic [PixW:0]     mask9;
  logic [PixW-1:0]   k_new;
  logic              ooa;
  logic [KeyW-1:0]   key_new;
  logic [KeyW-1:0]   hash_mix;
  logic [HB-1:0]     hash_new;
  logic [CodeW-1:0]  clear_new, clear_q;
  logic [WidthW-1:0] width_new, width_rst;
  logic [CodeW:0]    nf_new, nf_rst, nf_inc, grow_at;
  logic              table_full;

  assign mcs_new   = in_data_i.frame_start ? clamp_mcs(mcs_i) : fmcs_q;
  assign mask9     = (9'd1 << mcs_new) - 9'd1;
  assign k_new     = in_data_i.pixel_index & mask9[PixW-1:0];
  assign ooa       = (in_data_i.pixel_index >> mcs_new) != '0;
  assign key_new   = {cur_q, k_new};
  assign hash_mix  = key_new ^ (key_new >> HB) ^ {k_new, {CodeW{1'b0}}} >> (KeyW - HB);
  assign hash_new  = hash_mix[HB-1:0];
  assign clear_new = CodeW'(1) << mcs_new;
  assign width_new = mcs_new + WidthW'(1);
  assign nf_new    = (13'd1 << mcs_new) + 13'd2;
  assign clear_q   = CodeW'(1) << fmcs_q;
  assign width_rst = fmcs_q + WidthW'(1);
  assign nf_rst    = (13'd1 << fmcs_q) + 13'd2;
  assign nf_inc    = nf_q + 13'd1;
  assign grow_at   = (13'd1 << width_q) + 13'd1;
  assign table_full = nf_q >= 13'(CodeLimit);

  // status
  always_comb begin
    st_o            = '0;
    st_o.drop       = !in_data_i.frame_start && !active_q;
    st_o.item_fs    = in_data_i.frame_start;
    st_o.item_fe    = in_data_i.frame_end;
    st_o.fe_q       = fe_q;
    st_o.clr_done   = clr_cnt_q == HB'(HD - 1);
    st_o.slot_valid = ({1'b0, slot_rd_q.code} >= {1'b0, clear_q} + 13'd2) &&
                      ({1'b0, slot_rd_q.code} < nf_q) && (dict_rd_q == s_q);
    st_o.key_match  = slot_rd_q.key == key_q;
    st_o.table_full = table_full;
    st_o.oq_room    = cnt_q <= (OqPtrW+1)'(OqDepth - 4);
  end

  // state update and result selection
  always_comb begin
    nf_d      = nf_q;
    width_d   = width_q;
    fmcs_d    = fmcs_q;
    cur_d     = cur_q;
    k_d       = k_q;
    key_d     = key_q;
    s_d       = s_q;
    fe_d      = fe_q;
    active_d  = active_q;
    err_d     = err_q;
    serr_d    = serr_q;
    push      = 1'b0;
    push_data = '0;

    if (cmd_i.accept && !st_o.drop) begin
      k_d   = k_new;
      key_d = key_new;
      s_d   = hash_new;
      fe_d  = in_data_i.frame_end;
      if (in_data_i.frame_start) begin
        fmcs_d   = mcs_new;
        nf_d     = nf_new;
        width_d  = width_new;
        cur_d    = {{(CodeW-PixW){1'b0}}, k_new};
        active_d = 1'b1;
        serr_d   = ooa;
        err_d    = 1'b0;
        push     = 1'b1;
        push_data = '{code_value: clear_new, code_width: width_new,
                      last_of_run: !in_data_i.frame_end, symbol_error: ooa};
      end else begin
        serr_d = err_q | ooa;
        err_d  = err_q | ooa;
      end
    end

    if (cmd_i.probe_next) s_d = s_q + HB'(1);

    if (cmd_i.hit) cur_d = slot_rd_q.code;

    if (cmd_i.miss) begin
      push      = 1'b1;
      push_data = '{code_value: cur_q, code_width: width_q,
                    last_of_run: !fe_q && !table_full, symbol_error: serr_q};
      cur_d     = {{(CodeW-PixW){1'b0}}, k_q};
      if (!table_full) begin
        nf_d = nf_inc;
        if ((width_q < WidthW'(MAX_CODE_BITS)) && (nf_inc == grow_at))
          width_d = width_q + WidthW'(1);
      end
    end

    if (cmd_i.full_clear) begin
      push      = 1'b1;
      push_data = '{code_value: clear_q, code_width: width_q,
                    last_of_run: !fe_q, symbol_error: serr_q};
      nf_d      = nf_rst;
      width_d   = width_rst;
    end

    if (cmd_i.flush) begin
      push      = 1'b1;
      push_data = '{code_value: cur_q, code_width: width_q,
                    last_of_run: 1'b0, symbol_error: serr_q};
    end

    if (cmd_i.eoi) begin
      push      = 1'b1;
      push_data = '{code_value: clear_q + CodeW'(1), code_width: width_q,
                    last_of_run: 1'b1, symbol_error: serr_q};
      active_d  = 1'b0;
    end

    // any result of a pixel clears the pending error
    if (push && !cmd_i.accept) err_d = 1'b0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q      <= 13'd258;
      width_q   <= 4'd9;
      fmcs_q    <= McsReset;
      cur_q     <= '0;
      active_q  <= 1'b0;
      err_q     <= 1'b0;
      serr_q    <= 1'b0;
      fe_q      <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      nf_q     <= nf_d;
      width_q  <= width_d;
      fmcs_q   <= fmcs_d;
      cur_q    <= cur_d;
      active_q <= active_d;
      err_q    <= err_d;
      serr_q   <= serr_d;
      fe_q     <= fe_d;
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + HB'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    key_q <= key_d;
    s_q   <= s_d;
  end

  // hash slot table: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      slot_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.miss && !table_full) begin
      slot_mem[s_q] <= '{code: nf_q[CodeW-1:0], key: key_q};
    end
    if (cmd_i.probe_next) slot_rd_q <= slot_mem[s_q + HB'(1)];
    else if (cmd_i.accept) slot_rd_q <= slot_mem[hash_new];
  end

  // code table: slot each live code sits in
  always_ff @(posedge clk_i) begin
    if (cmd_i.miss && !table_full) dict_mem[nf_q[DW-1:0]] <= s_q;
    if (cmd_i.dict_rd) dict_rd_q <= dict_mem[slot_rd_q.code[DW-1:0]];
  end

  // result queue
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = oq_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) oq_mem[wr_ptr_q] <= push_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + OqPtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + OqPtrW'(1);
      cnt_q <= cnt_q + (OqPtrW+1)'(push) - (OqPtrW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

### verif/gif_lzw_encoder_tb.sv
// ----------------------------------------------------------------------------
// gif_lzw_encoder_tb
// Self-checking bench for the GIF LZW encoder. Pixels are sent in frames over
// the input channel. A built-in LZW predictor works out the codes each pixel
// should produce, and every output beat is compared against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gif_lzw_encoder_tb;
  import gle_pkg::*;

  localparam int TblDepth  = TableDepthDef;
  localparam int MaxBits   = MaxCodeBitsDef;
  localparam int CodeLimit = (TblDepth < (1 << MaxBits)) ? TblDepth : (1 << MaxBits);
  localparam int CycleLimit = 900000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;
  logic      psel;
  logic      penable;
  logic      pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gif_lzw_encoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Predictor state
  logic [19:0] dict_q [TblDepth];
  logic [11:0] cur_code;
  int unsigned next_code;
  int unsigned cur_width;
  int unsigned mcs_reg;
  int unsigned frame_mcs;
  bit          in_frame;
  bit          err_pend;

  out_beat_t   code_q[$];
  int          n_mismatch;
  int          n_codes;
  int          n_pixels;
  longint      cycles;
  bit          quiet;      // no idling on either side

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("** gif_lzw_encoder: FAILED **");
        $finish;
      end
    end
  end

  function automatic void dict_restart();
    next_code = (1 << frame_mcs) + 2;
    cur_width = frame_mcs + 1;
  endfunction

  function automatic void model_reset();
    mcs_reg   = 8;
    frame_mcs = 8;
    cur_code  = '0;
    in_frame  = 1'b0;
    err_pend  = 1'b0;
    dict_restart();
  endfunction

  // Work out the codes one pixel produces and queue them
  function automatic void predict_codes(in_beat_t b);
    out_beat_t   res[$];
    int unsigned clr, sym, key, i;
    bit          hit;
    out_beat_t   o;
    if (b.frame_start) begin
      frame_mcs = (mcs_reg < 2) ? 2 : (mcs_reg > 8) ? 8 : mcs_reg;
      err_pend  = 1'b0;
      dict_restart();
      o = '0; o.code_value = 12'(1 << frame_mcs); o.code_width = 4'(cur_width);
      res = {res, o};
    end else if (!in_frame) begin
      return;
    end
    clr = 1 << frame_mcs;
    if (b.pixel_index >= clr) err_pend = 1'b1;
    sym = b.pixel_index & (clr - 1);
    if (b.frame_start) begin
      cur_code = 12'(sym);
      in_frame = 1'b1;
    end else begin
      key = (int'(cur_code) << 8) | sym;
      hit = 1'b0;
      for (i = clr + 2; i < next_code && i < TblDepth; i++)
        if (dict_q[i] == 20'(key)) begin
          hit = 1'b1;
          break;
        end
      if (hit) begin
        cur_code = 12'(i);
      end else begin
        o = '0; o.code_value = cur_code; o.code_width = 4'(cur_width);
        res = {res, o};
        if (next_code < CodeLimit) begin
          dict_q[next_code] = 20'(key);
          next_code++;
          if (cur_width < MaxBits && next_code == (1 << cur_width) + 1) cur_width++;
        end else begin
          o = '0; o.code_value = 12'(clr); o.code_width = 4'(cur_width);
          res = {res, o};
          dict_restart();
        end
        cur_code = 12'(sym);
      end
    end
    if (b.frame_end) begin
      o = '0; o.code_value = cur_code; o.code_width = 4'(cur_width);
      res = {res, o};
      o = '0; o.code_value = 12'(clr + 1); o.code_width = 4'(cur_width);
      res = {res, o};
      in_frame = 1'b0;
    end
    foreach (res[r]) begin
      res[r].symbol_error = err_pend;
      res[r].last_of_run  = (r == res.size() - 1);
      code_q = {code_q, res[r]};
    end
    if (res.size() > 0) err_pend = 1'b0;
  endfunction

  // Send one pixel beat, with a random idle gap first; valid stays high
  // afterwards so beats can follow back to back, drain() drops it
  task automatic send_pixel(logic [7:0] pix, bit fs, bit fe);
    in_beat_t b;
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    b.pixel_index = pix;
    b.frame_start = fs;
    b.frame_end   = fe;
    in_data_i  <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_codes(b);
    n_pixels++;
    @(negedge clk_i);
  endtask

  // Output side: random stalls, then check each accepted beat
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 17);
  end

  always @(posedge clk_i) begin
    out_beat_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_codes++;
      if (code_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected code beat %p", out_data_o);
      end else begin
        exp_b = code_q.pop_front();
        if (out_data_o.code_value !== exp_b.code_value ||
            out_data_o.code_width !== exp_b.code_width ||
            out_data_o.last_of_run !== exp_b.last_of_run ||
            out_data_o.symbol_error !== exp_b.symbol_error) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected %p got %p", exp_b, out_data_o);
        end
      end
    end
  end

  // Stop the input, wait for all codes, then a few more cycles
  task automatic drain();
    int guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (code_q.size() != 0 && guard < 50000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (40) @(negedge clk_i);
  endtask

  // APB register write, setup then access phase
  task automatic write_mcs(int unsigned v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * RegMcs);
    pwdata  <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mcs_reg = v & 4'hF;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random frame: mostly short palettes so strings repeat and hit
  task automatic random_frame(int len, int unsigned alpha);
    for (int i = 0; i < len; i++) begin
      logic [7:0] p;
      if ($urandom_range(99) < 5) p = 8'($urandom_range(255));
      else p = 8'($urandom_range(alpha - 1));
      send_pixel(p, i == 0, i == len - 1);
    end
  endtask

  task automatic test_directed();
    // reset mcs 8: extremes, single-pixel frame
    send_pixel(8'h00, 1, 1);
    send_pixel(8'hFF, 1, 1);
    // pixel outside a frame is ignored
    send_pixel(8'h12, 0, 0);
    // repeating string, then restart inside a frame
    send_pixel(8'hAA, 1, 0);
    send_pixel(8'hAA, 0, 0);
    send_pixel(8'hAA, 0, 0);
    send_pixel(8'hAA, 0, 0);
    send_pixel(8'h55, 1, 0);
    send_pixel(8'h55, 0, 0);
    send_pixel(8'h55, 0, 1);
    // smallest code size with out-of-alphabet pixels
    write_mcs(2);
    send_pixel(8'h03, 1, 0);
    send_pixel(8'h04, 0, 0);
    send_pixel(8'h80, 0, 0);
    send_pixel(8'h01, 0, 0);
    send_pixel(8'h03, 0, 1);
    // clamped sizes
    write_mcs(0);
    send_pixel(8'h07, 1, 1);
    write_mcs(15);
    send_pixel(8'hFE, 1, 0);
    send_pixel(8'h01, 0, 1);
  endtask

  // Long frame at mcs 2: several width steps
  task automatic test_long_frame();
    write_mcs(2);
    for (int i = 0; i < 200; i++) begin
      send_pixel(8'($urandom_range(3)), i == 0, i == 199);
    end
  endtask

  task automatic test_random();
    int unsigned sizes[5] = '{2, 3, 5, 8, 4};
    for (int s = 0; s < 5; s++) begin
      write_mcs(sizes[s]);
      quiet = (s == 2);
      for (int f = 0; f < 4; f++)
        random_frame($urandom_range(5, 30), 1 << ((sizes[s] > 4) ? 4 : sizes[s]));
      // noise between frames
      send_pixel(8'($urandom_range(255)), 0, $urandom_range(1));
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    n_mismatch = 0; n_codes = 0; n_pixels = 0; quiet = 1'b0;
    model_reset();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_long_frame();
    test_random();
    drain();
    if (code_q.size() != 0) begin
      n_mismatch++;
      $display("%0d expected codes never arrived", code_q.size());
    end
    $display("sent %0d pixels over several code sizes, checked %0d codes",
             n_pixels, n_codes);
    $display("width growth, clamped sizes and stray pixels were covered");
    if (n_mismatch == 0) $display("** gif_lzw_encoder: PASSED **");
    else $display("** gif_lzw_encoder: FAILED **");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/gle_pkg.sv
rtl/gle_ctrl.sv
rtl/gle_dp.sv
rtl/gif_lzw_encoder.sv
verif/gif_lzw_encoder_tb.sv
